>>> sv/kettle_fill_heat_controller_unit_defines.svh
// Assertion macros for the kettle fill and heat controller checker.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef KETTLE_FILL_HEAT_CONTROLLER_UNIT_DEFINES_SVH
`define KETTLE_FILL_HEAT_CONTROLLER_UNIT_DEFINES_SVH

// The consequent must hold on every edge at which the antecedent holds.
`define KFH_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The condition must never be seen while reset is released.
`define KFH_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

>>> sv/kfh_pkg.sv
// Shared types and constants for the kettle fill and heat controller.
// Used by the interfaces, the register block, the control core and the top level.
`timescale 1ns / 1ps

package kfh_pkg;

    localparam int TEMP_W          = 12;
    localparam int OPCODE_W        = 3;
    localparam int DEBOUNCE_W      = 16;
    localparam int TIMEOUT_W       = 24;
    localparam int CFG_DATA_W      = 24;
    localparam int CFG_INDEX_W     = 2;
    localparam int TIMER_BITS_DEF  = 24;

    localparam logic [DEBOUNCE_W-1:0]    DEBOUNCE_RESET = 16'd50;
    localparam logic [TIMEOUT_W-1:0]     PUMP_TO_RESET  = 24'd120000;
    localparam logic [TIMEOUT_W-1:0]     HEAT_TO_RESET  = 24'd600000;
    localparam logic signed [TEMP_W-1:0] TARGET_RESET   = 12'sd1600;

    typedef enum logic [OPCODE_W-1:0] {
        OP_NONE        = 3'd0,
        OP_PUMP_TOGGLE = 3'd1,
        OP_HEAT_ON     = 3'd2,
        OP_HEAT_OFF    = 3'd3,
        OP_FILL_HEAT   = 3'd4
    } opcode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DEBOUNCE = 2'd0,
        CFG_PUMP_TO  = 2'd1,
        CFG_HEAT_TO  = 2'd2,
        CFG_TARGET   = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [DEBOUNCE_W-1:0]    debounce_ms;
        logic [TIMEOUT_W-1:0]     pump_timeout_ms;
        logic [TIMEOUT_W-1:0]     heat_timeout_ms;
        logic signed [TEMP_W-1:0] target_temp;
    } cfg_t;

    typedef struct packed {
        logic                     float_level;
        logic signed [TEMP_W-1:0] temperature;
        logic [OPCODE_W-1:0]      opcode;
    } item_t;

    typedef struct packed {
        logic pump_drive;
        logic heat_active;
        logic kettle_full;
        logic heat_pending;
        logic arm_press_on;
        logic arm_press_off;
    } result_t;

endpackage

>>> sv/kfh_if.sv
// Handshake channels for the tick items and the result items.
// Depends on kfh_pkg for field widths.
`timescale 1ns / 1ps

interface kfh_tick_if;
    logic                              valid;
    logic                              ready;
    logic                              float_level;
    logic signed [kfh_pkg::TEMP_W-1:0] temperature;
    logic [kfh_pkg::OPCODE_W-1:0]      opcode;

    modport source (output valid, output float_level, output temperature,
                    output opcode, input ready);
    modport sink   (input valid, input float_level, input temperature,
                    input opcode, output ready);
endinterface

interface kfh_result_if;
    logic valid;
    logic ready;
    logic pump_drive;
    logic heat_active;
    logic kettle_full;
    logic heat_pending;
    logic arm_press_on;
    logic arm_press_off;

    modport source (output valid, output pump_drive, output heat_active,
                    output kettle_full, output heat_pending, output arm_press_on,
                    output arm_press_off, input ready);
    modport sink   (input valid, input pump_drive, input heat_active,
                    input kettle_full, input heat_pending, input arm_press_on,
                    input arm_press_off, output ready);
endinterface

>>> sv/kfh_cfg_regs.sv
// Configuration register file: debounce time, pump and heat limits, target.
// Depends on kfh_pkg for the register indexes and the configuration struct.
`timescale 1ns / 1ps

module kfh_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [kfh_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [kfh_pkg::CFG_DATA_W-1:0]   cfg_data,
    output kfh_pkg::cfg_t                    cfg
);

    kfh_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms     <= kfh_pkg::DEBOUNCE_RESET;
            cfg_reg.pump_timeout_ms <= kfh_pkg::PUMP_TO_RESET;
            cfg_reg.heat_timeout_ms <= kfh_pkg::HEAT_TO_RESET;
            cfg_reg.target_temp     <= kfh_pkg::TARGET_RESET;
        end
        else if (cfg_we)
        begin
            case (kfh_pkg::cfg_index_t'(cfg_index))
                kfh_pkg::CFG_DEBOUNCE:
                    cfg_reg.debounce_ms <= cfg_data[kfh_pkg::DEBOUNCE_W-1:0];
                kfh_pkg::CFG_PUMP_TO:
                    cfg_reg.pump_timeout_ms <= cfg_data[kfh_pkg::TIMEOUT_W-1:0];
                kfh_pkg::CFG_HEAT_TO:
                    cfg_reg.heat_timeout_ms <= cfg_data[kfh_pkg::TIMEOUT_W-1:0];
                kfh_pkg::CFG_TARGET:
                    cfg_reg.target_temp <= $signed(cfg_data[kfh_pkg::TEMP_W-1:0]);
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> sv/kfh_core.sv
// Control core: debounce, timers, opcode handling and the safety rules.
// Holds the controller state and produces the result of the item being retired.
// Depends on kfh_pkg.
`timescale 1ns / 1ps

module kfh_core #(
    parameter int TIMER_BITS = kfh_pkg::TIMER_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  kfh_pkg::item_t   item,
    input  kfh_pkg::cfg_t    cfg,
    output kfh_pkg::result_t res
);

    localparam int CMP_W = (TIMER_BITS > kfh_pkg::TIMEOUT_W) ? TIMER_BITS : kfh_pkg::TIMEOUT_W;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};
    localparam logic [kfh_pkg::DEBOUNCE_W-1:0] STABLE_MAX = {kfh_pkg::DEBOUNCE_W{1'b1}};

    logic                           last_level_reg, last_level_next;
    logic [kfh_pkg::DEBOUNCE_W-1:0] stable_ms_reg, stable_ms_next;
    logic                           full_reg, full_next;
    logic                           pump_reg, pump_next;
    logic                           heat_reg, heat_next;
    logic                           pending_reg, pending_next;
    logic [TIMER_BITS-1:0]          pump_ms_reg, pump_ms_next;
    logic [TIMER_BITS-1:0]          heat_ms_reg, heat_ms_next;
    logic                           press_on, press_off;
    logic                           pump_expired, heat_expired, too_hot;

    always_comb
    begin
        pump_ms_next = pump_ms_reg;
        heat_ms_next = heat_ms_reg;
        if (pump_reg && pump_ms_reg != TIMER_MAX)
            pump_ms_next = pump_ms_reg + 1'b1;
        if (heat_reg && heat_ms_reg != TIMER_MAX)
            heat_ms_next = heat_ms_reg + 1'b1;

        if (item.float_level != last_level_reg)
            stable_ms_next = '0;
        else if (stable_ms_reg != STABLE_MAX)
            stable_ms_next = stable_ms_reg + 1'b1;
        else
            stable_ms_next = stable_ms_reg;
        full_next = (stable_ms_next > cfg.debounce_ms) ? item.float_level : full_reg;
        last_level_next = item.float_level;

        pump_next    = pump_reg;
        heat_next    = heat_reg;
        pending_next = pending_reg;
        press_on     = 1'b0;
        press_off    = 1'b0;

        case (kfh_pkg::opcode_t'(item.opcode))
            kfh_pkg::OP_PUMP_TOGGLE:
            begin
                if (pump_reg)
                    pump_next = 1'b0;
                else if (!full_next)
                begin
                    pump_next    = 1'b1;
                    pump_ms_next = '0;
                end
            end
            kfh_pkg::OP_HEAT_ON:
            begin
                if (full_next)
                begin
                    press_on     = 1'b1;
                    heat_ms_next = '0;
                    heat_next    = 1'b1;
                end
            end
            kfh_pkg::OP_HEAT_OFF:
            begin
                press_off = 1'b1;
                heat_next = 1'b0;
            end
            kfh_pkg::OP_FILL_HEAT:
            begin
                pending_next = 1'b1;
                if (full_next)
                    pump_next = 1'b0;
                else if (!pump_reg)
                begin
                    pump_next    = 1'b1;
                    pump_ms_next = '0;
                end
            end
            default:
            begin
                pump_next = pump_reg;
            end
        endcase

        pump_expired = CMP_W'(pump_ms_next) >= CMP_W'(cfg.pump_timeout_ms);
        if (full_next)
        begin
            pump_next = 1'b0;
            if (pending_next)
            begin
                pending_next = 1'b0;
                press_on     = 1'b1;
                heat_ms_next = '0;
                heat_next    = 1'b1;
            end
        end
        else
        begin
            if (heat_next)
            begin
                press_off = 1'b1;
                heat_next = 1'b0;
            end
            if (pump_next && pump_expired)
                pump_next = 1'b0;
        end

        too_hot      = item.temperature >= cfg.target_temp;
        heat_expired = CMP_W'(heat_ms_next) >= CMP_W'(cfg.heat_timeout_ms);
        if (heat_next && (too_hot || heat_expired))
        begin
            press_off = 1'b1;
            heat_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_level_reg <= 1'b0;
            stable_ms_reg  <= '0;
            full_reg       <= 1'b0;
            pump_reg       <= 1'b0;
            heat_reg       <= 1'b0;
            pending_reg    <= 1'b0;
            pump_ms_reg    <= '0;
            heat_ms_reg    <= '0;
        end
        else if (fire)
        begin
            last_level_reg <= last_level_next;
            stable_ms_reg  <= stable_ms_next;
            full_reg       <= full_next;
            pump_reg       <= pump_next;
            heat_reg       <= heat_next;
            pending_reg    <= pending_next;
            pump_ms_reg    <= pump_ms_next;
            heat_ms_reg    <= heat_ms_next;
        end
    end

    assign res.pump_drive    = pump_next;
    assign res.heat_active   = heat_next;
    assign res.kettle_full   = full_next;
    assign res.heat_pending  = pending_next;
    assign res.arm_press_on  = press_on;
    assign res.arm_press_off = press_off;

endmodule

>>> sv/kettle_fill_heat_controller_unit.sv
// Kettle fill and heat controller, top level.
// Each tick item is registered in the input register and its result in the output register.
// Throughput: one item per cycle; a stalled result holds at most one further
// item in the input register, after which the tick input stops taking items.
// Reset clears all control state and loads the register defaults.
`timescale 1ns / 1ps

module kettle_fill_heat_controller_unit #(
    parameter int TIMER_BITS = kfh_pkg::TIMER_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    kfh_tick_if.sink                        tick,
    kfh_result_if.source                    result,
    input  logic                            cfg_we,
    input  logic [kfh_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [kfh_pkg::CFG_DATA_W-1:0]  cfg_data
);

    kfh_pkg::cfg_t    cfg;
    kfh_pkg::item_t   item_reg;
    logic             item_valid_reg;
    kfh_pkg::result_t res_next;
    kfh_pkg::result_t res_reg;
    logic             res_valid_reg;
    logic             res_free;
    logic             fire;

    assign res_free   = !res_valid_reg || result.ready;
    assign fire       = item_valid_reg && res_free;
    assign tick.ready = !item_valid_reg || fire;

    kfh_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    kfh_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item_reg),
        .cfg   (cfg),
        .res   (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (tick.ready)
            item_valid_reg <= tick.valid;
    end

    always_ff @(posedge clk)
    begin
        if (tick.valid && tick.ready)
        begin
            item_reg.float_level <= tick.float_level;
            item_reg.temperature <= tick.temperature;
            item_reg.opcode      <= tick.opcode;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (res_free)
            res_valid_reg <= fire;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            res_reg <= res_next;
    end

    assign result.valid         = res_valid_reg;
    assign result.pump_drive    = res_reg.pump_drive;
    assign result.heat_active   = res_reg.heat_active;
    assign result.kettle_full   = res_reg.kettle_full;
    assign result.heat_pending  = res_reg.heat_pending;
    assign result.arm_press_on  = res_reg.arm_press_on;
    assign result.arm_press_off = res_reg.arm_press_off;

endmodule

>>> sv/kfh_checker.sv
// Port-level checks on the result items of the kettle controller.
// Uses the macros of kettle_fill_heat_controller_unit_defines.svh; bound to the top level.
`timescale 1ns / 1ps
`include "kettle_fill_heat_controller_unit_defines.svh"

module kfh_checker (
    input logic clk,
    input logic rst_n,
    input logic res_valid,
    input logic pump_drive,
    input logic heat_active,
    input logic kettle_full,
    input logic heat_pending,
    input logic arm_press_on,
    input logic arm_press_off
);

    // The pump never runs into a full kettle.
    `KFH_ASSERT_NEVER(a_pump_when_full, res_valid && pump_drive && kettle_full, "pump on while full")
    // Heating is only reported with the kettle full.
    `KFH_ASSERT_IMPLY(a_heat_needs_full, res_valid && heat_active, kettle_full, "heat without full")
    // A pending fill-and-heat is consumed as soon as the kettle is full.
    `KFH_ASSERT_NEVER(a_pending_when_full, res_valid && heat_pending && kettle_full, "pending while full")
    // An on press that is not followed by an off press leaves the heat running.
    `KFH_ASSERT_IMPLY(a_press_on_heats, res_valid && arm_press_on && !arm_press_off, heat_active, "press on without heat")

endmodule

bind kettle_fill_heat_controller_unit kfh_checker u_kfh_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (result.valid),
    .pump_drive    (result.pump_drive),
    .heat_active   (result.heat_active),
    .kettle_full   (result.kettle_full),
    .heat_pending  (result.heat_pending),
    .arm_press_on  (result.arm_press_on),
    .arm_press_off (result.arm_press_off)
);

>>> tb/kettle_fill_heat_controller_unit_test.sv
// Self-checking testbench for the kettle fill and heat controller top level.
// A directed table and random phases are checked against an in-bench model; typed rows use the table's results.
// Depends on kfh_pkg, the kfh interfaces and kettle_fill_heat_controller_unit.
`timescale 1ns / 1ps

module kettle_fill_heat_controller_unit_test;

    localparam logic [kfh_pkg::TIMEOUT_W-1:0] TIMER_MAX = {kfh_pkg::TIMEOUT_W{1'b1}};

    typedef struct packed {
        logic                           is_reg;
        kfh_pkg::cfg_index_t            idx;
        logic [kfh_pkg::CFG_DATA_W-1:0] data;
        kfh_pkg::item_t                 item;
        logic                           typed;
        kfh_pkg::result_t               want;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [kfh_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [kfh_pkg::CFG_DATA_W-1:0] cfg_data;

    kfh_tick_if   tick_ch ();
    kfh_result_if res_ch ();

    kettle_fill_heat_controller_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick_ch),
        .result    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    logic [kfh_pkg::DEBOUNCE_W-1:0]    c_debounce;
    logic [kfh_pkg::TIMEOUT_W-1:0]     c_pump_to;
    logic [kfh_pkg::TIMEOUT_W-1:0]     c_heat_to;
    logic signed [kfh_pkg::TEMP_W-1:0] c_target;

    logic                           m_last;
    logic [kfh_pkg::DEBOUNCE_W-1:0] m_stable;
    logic                           m_full;
    logic                           m_pump;
    logic                           m_heat;
    logic                           m_pending;
    logic [kfh_pkg::TIMEOUT_W-1:0]  m_pump_ms;
    logic [kfh_pkg::TIMEOUT_W-1:0]  m_heat_ms;
    logic                           m_press_on;
    logic                           m_press_off;

    kfh_pkg::result_t status_q[$];
    dir_row_t         dir_rows[$];
    int               fail_count;
    bit               idle_en;
    int               stall_left;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic void start_pump();
        if (!m_full)
        begin
            if (!m_pump)
            begin
                m_pump    = 1'b1;
                m_pump_ms = '0;
            end
        end
        else
        begin
            m_pump = 1'b0;
        end
    endfunction

    function automatic void start_heat();
        if (m_full)
        begin
            m_press_on = 1'b1;
            m_heat_ms  = '0;
            m_heat     = 1'b1;
        end
    endfunction

    function automatic void stop_heat();
        m_press_off = 1'b1;
        m_heat      = 1'b0;
    endfunction

    function automatic kfh_pkg::result_t step_controller(input kfh_pkg::item_t it);
        kfh_pkg::result_t r;
        m_press_on  = 1'b0;
        m_press_off = 1'b0;
        if (m_pump && m_pump_ms != TIMER_MAX)
            m_pump_ms = m_pump_ms + 1'b1;
        if (m_heat && m_heat_ms != TIMER_MAX)
            m_heat_ms = m_heat_ms + 1'b1;
        if (it.float_level != m_last)
            m_stable = '0;
        else if (m_stable != {kfh_pkg::DEBOUNCE_W{1'b1}})
            m_stable = m_stable + 1'b1;
        if (m_stable > c_debounce)
            m_full = it.float_level;
        m_last = it.float_level;
        case (it.opcode)
            kfh_pkg::OP_PUMP_TOGGLE:
                if (m_pump)
                    m_pump = 1'b0;
                else
                    start_pump();
            kfh_pkg::OP_HEAT_ON:  start_heat();
            kfh_pkg::OP_HEAT_OFF: stop_heat();
            kfh_pkg::OP_FILL_HEAT:
            begin
                m_pending = 1'b1;
                start_pump();
            end
            default: ;
        endcase
        if (m_full)
        begin
            m_pump = 1'b0;
            if (m_pending)
            begin
                m_pending = 1'b0;
                start_heat();
            end
        end
        else
        begin
            if (m_heat)
                stop_heat();
            if (m_pump && m_pump_ms >= c_pump_to)
                m_pump = 1'b0;
        end
        if (m_heat && ($signed(it.temperature) >= $signed(c_target) || m_heat_ms >= c_heat_to))
            stop_heat();
        r.pump_drive    = m_pump;
        r.heat_active   = m_heat;
        r.kettle_full   = m_full;
        r.heat_pending  = m_pending;
        r.arm_press_on  = m_press_on;
        r.arm_press_off = m_press_off;
        return r;
    endfunction

    task automatic add_tick(input logic lvl, input int temp, input int op,
                            input logic typed, input kfh_pkg::result_t want);
        dir_row_t row;
        row = '0;
        row.item.float_level = lvl;
        row.item.temperature = kfh_pkg::TEMP_W'(temp);
        row.item.opcode      = kfh_pkg::OPCODE_W'(op);
        row.typed            = typed;
        row.want             = want;
        dir_rows.push_back(row);
    endtask

    task automatic add_reg(input kfh_pkg::cfg_index_t idx, input int val);
        dir_row_t row;
        row        = '0;
        row.is_reg = 1'b1;
        row.idx    = idx;
        row.data   = kfh_pkg::CFG_DATA_W'(val);
        dir_rows.push_back(row);
    endtask

    task automatic write_reg(input kfh_pkg::cfg_index_t idx,
                             input logic [kfh_pkg::CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            kfh_pkg::CFG_DEBOUNCE: c_debounce = val[kfh_pkg::DEBOUNCE_W-1:0];
            kfh_pkg::CFG_PUMP_TO:  c_pump_to  = val[kfh_pkg::TIMEOUT_W-1:0];
            kfh_pkg::CFG_HEAT_TO:  c_heat_to  = val[kfh_pkg::TIMEOUT_W-1:0];
            kfh_pkg::CFG_TARGET:   c_target   = val[kfh_pkg::TEMP_W-1:0];
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        tick_ch.valid <= 1'b0;
        while (status_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_tick(input kfh_pkg::item_t it, input logic typed,
                             input kfh_pkg::result_t want);
        kfh_pkg::result_t pred;
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            tick_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        tick_ch.valid       <= 1'b1;
        tick_ch.float_level <= it.float_level;
        tick_ch.temperature <= it.temperature;
        tick_ch.opcode      <= it.opcode;
        @(posedge clk);
        while (!tick_ch.ready)
            @(posedge clk);
        pred = step_controller(it);
        status_q.push_back(typed ? want : pred);
    endtask

    always @(posedge clk)
    begin
        kfh_pkg::result_t got;
        kfh_pkg::result_t exp_r;
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                got.pump_drive    = res_ch.pump_drive;
                got.heat_active   = res_ch.heat_active;
                got.kettle_full   = res_ch.kettle_full;
                got.heat_pending  = res_ch.heat_pending;
                got.arm_press_on  = res_ch.arm_press_on;
                got.arm_press_off = res_ch.arm_press_off;
                if (status_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result item %b", got);
                end
                else
                begin
                    exp_r = status_q.pop_front();
                    if (got.pump_drive !== exp_r.pump_drive
                        || got.heat_active !== exp_r.heat_active
                        || got.kettle_full !== exp_r.kettle_full
                        || got.heat_pending !== exp_r.heat_pending
                        || got.arm_press_on !== exp_r.arm_press_on
                        || got.arm_press_off !== exp_r.arm_press_off)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch at %0t: pump/heat/full/pend/on/off exp %b got %b",
                                     $realtime, exp_r, got);
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end
            else if (idle_en && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 9) - 1;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("kettle_fill_heat_controller_unit_test: done, errors");
        $finish;
    end

    initial
    begin
        dir_row_t         row;
        kfh_pkg::item_t   it;
        kfh_pkg::result_t none_r;
        kfh_pkg::result_t off_r;
        int               deb;
        int               pto;
        int               hto;
        int               tgt;
        int               temp;
        int               sel;
        int               run_left;
        logic             lvl;

        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        tick_ch.valid       = 1'b0;
        tick_ch.float_level = 1'b0;
        tick_ch.temperature = '0;
        tick_ch.opcode      = '0;
        res_ch.ready        = 1'b0;
        fail_count          = 0;
        idle_en             = 1'b1;
        stall_left          = 0;

        c_debounce = kfh_pkg::DEBOUNCE_RESET;
        c_pump_to  = kfh_pkg::PUMP_TO_RESET;
        c_heat_to  = kfh_pkg::HEAT_TO_RESET;
        c_target   = kfh_pkg::TARGET_RESET;
        m_last     = 1'b0;
        m_stable   = '0;
        m_full     = 1'b0;
        m_pump     = 1'b0;
        m_heat     = 1'b0;
        m_pending  = 1'b0;
        m_pump_ms  = '0;
        m_heat_ms  = '0;

        none_r = '0;
        off_r  = '0;
        off_r.arm_press_off = 1'b1;

        // Register defaults after reset, then the zero limits, then long
        // limits with a reachable target, then a debounce that never settles.
        add_tick(1'b0, 0, kfh_pkg::OP_NONE, 1'b1, none_r);
        add_tick(1'b0, -880, kfh_pkg::OP_HEAT_ON, 1'b1, none_r);
        add_tick(1'b0, 2000, kfh_pkg::OP_HEAT_OFF, 1'b1, off_r);
        add_tick(1'b0, 100, kfh_pkg::OP_PUMP_TOGGLE, 1'b0, none_r);
        add_tick(1'b0, 100, kfh_pkg::OP_PUMP_TOGGLE, 1'b0, none_r);
        add_tick(1'b0, 100, kfh_pkg::OP_FILL_HEAT, 1'b0, none_r);
        add_tick(1'b1, 100, 5, 1'b0, none_r);
        add_tick(1'b1, 100, 6, 1'b0, none_r);
        add_tick(1'b1, 100, 7, 1'b0, none_r);
        add_reg(kfh_pkg::CFG_DEBOUNCE, 0);
        add_reg(kfh_pkg::CFG_PUMP_TO, 0);
        add_reg(kfh_pkg::CFG_HEAT_TO, 0);
        add_reg(kfh_pkg::CFG_TARGET, 2000);
        add_tick(1'b1, -880, kfh_pkg::OP_PUMP_TOGGLE, 1'b0, none_r);
        add_tick(1'b1, -880, kfh_pkg::OP_HEAT_ON, 1'b0, none_r);
        add_tick(1'b1, 0, kfh_pkg::OP_FILL_HEAT, 1'b0, none_r);
        add_tick(1'b0, 0, kfh_pkg::OP_NONE, 1'b0, none_r);
        add_tick(1'b0, 0, kfh_pkg::OP_NONE, 1'b0, none_r);
        add_tick(1'b0, 0, kfh_pkg::OP_PUMP_TOGGLE, 1'b0, none_r);
        add_reg(kfh_pkg::CFG_PUMP_TO, 24'hFFFFFF);
        add_reg(kfh_pkg::CFG_HEAT_TO, 24'hFFFFFF);
        add_reg(kfh_pkg::CFG_TARGET, 1000);
        add_tick(1'b1, 500, kfh_pkg::OP_NONE, 1'b0, none_r);
        add_tick(1'b1, 500, kfh_pkg::OP_NONE, 1'b0, none_r);
        add_tick(1'b1, 500, kfh_pkg::OP_HEAT_ON, 1'b0, none_r);
        add_tick(1'b1, 999, kfh_pkg::OP_HEAT_ON, 1'b0, none_r);
        add_tick(1'b1, 1000, kfh_pkg::OP_NONE, 1'b0, none_r);
        add_tick(1'b1, 1000, kfh_pkg::OP_HEAT_OFF, 1'b0, none_r);
        add_reg(kfh_pkg::CFG_DEBOUNCE, 65535);
        add_tick(1'b0, 0, kfh_pkg::OP_NONE, 1'b0, none_r);
        add_tick(1'b0, 0, kfh_pkg::OP_NONE, 1'b0, none_r);
        add_tick(1'b1, 2000, kfh_pkg::OP_FILL_HEAT, 1'b0, none_r);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            if (row.is_reg)
            begin
                wait_drained();
                write_reg(row.idx, row.data);
            end
            else
            begin
                send_tick(row.item, row.typed, row.want);
            end
        end

        lvl      = 1'b0;
        run_left = 0;
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0:
                begin
                    deb = 0;
                    pto = 0;
                    hto = 0;
                    tgt = -880;
                end
                1:
                begin
                    deb = 65535;
                    pto = 24'hFFFFFF;
                    hto = 24'hFFFFFF;
                    tgt = 2000;
                end
                default:
                begin
                    deb = $urandom_range(0, 6);
                    pto = $urandom_range(1, 40);
                    hto = $urandom_range(1, 60);
                    tgt = $urandom_range(0, 2880) - 880;
                end
            endcase
            wait_drained();
            if (p == 5)
                idle_en = 1'b0;
            write_reg(kfh_pkg::CFG_DEBOUNCE, kfh_pkg::CFG_DATA_W'(deb));
            write_reg(kfh_pkg::CFG_PUMP_TO, kfh_pkg::CFG_DATA_W'(pto));
            write_reg(kfh_pkg::CFG_HEAT_TO, kfh_pkg::CFG_DATA_W'(hto));
            write_reg(kfh_pkg::CFG_TARGET, kfh_pkg::CFG_DATA_W'(tgt));
            for (int k = 0; k < 180; k++)
            begin
                if (p == 3 && k == 90)
                    wait_drained();
                if (run_left == 0)
                begin
                    lvl      = ~lvl;
                    run_left = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 14);
                end
                run_left--;
                it.float_level = ($urandom_range(0, 19) == 0) ? ~lvl : lvl;
                if ($urandom_range(0, 9) < 7)
                begin
                    temp = tgt - 40 + $urandom_range(0, 45);
                    if (temp < -880)
                        temp = -880;
                    if (temp > 2000)
                        temp = 2000;
                end
                else
                begin
                    temp = $urandom_range(0, 2880) - 880;
                end
                it.temperature = kfh_pkg::TEMP_W'(temp);
                sel = $urandom_range(0, 99);
                if (sel < 55)
                    it.opcode = kfh_pkg::OP_NONE;
                else if (sel < 65)
                    it.opcode = kfh_pkg::OP_PUMP_TOGGLE;
                else if (sel < 75)
                    it.opcode = kfh_pkg::OP_HEAT_ON;
                else if (sel < 83)
                    it.opcode = kfh_pkg::OP_HEAT_OFF;
                else if (sel < 97)
                    it.opcode = kfh_pkg::OP_FILL_HEAT;
                else
                    it.opcode = kfh_pkg::OPCODE_W'($urandom_range(5, 7));
                send_tick(it, 1'b0, none_r);
            end
        end

        wait_drained();
        if (fail_count == 0)
            $display("kettle_fill_heat_controller_unit_test: done, clean");
        else
            $display("kettle_fill_heat_controller_unit_test: done, errors");
        $finish;
    end

endmodule
